@@ src/pfd_pkg.sv @@
// Shared constants, types and helpers of the Playfair digraph decrypter.
package pfd_pkg;

    localparam int SIDE      = 5;
    localparam int CELLS     = SIDE * SIDE;
    localparam int STEP_BACK = SIDE - 1;
    localparam int BYTE_W    = 8;
    localparam int SLOT_W    = 5;
    localparam int POS_W     = 3;

    typedef enum logic {
        CMD_LOAD    = 1'b0,
        CMD_DECRYPT = 1'b1
    } cmd_t;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [POS_W-1:0]  pos_t;

    // one cell's comparison against both cipher bytes
    typedef struct packed {
        logic first;
        logic second;
    } lane_hit_t;

    // cells to read out for one digraph
    typedef struct packed {
        slot_t addr_first;
        slot_t addr_second;
        logic  not_found;
    } target_t;

    // one step back round the square, wrapping (p is always below SIDE)
    function automatic pos_t step_back(pos_t p);
        pos_t r;
        if (p == '0)
            r = POS_W'(STEP_BACK);
        else
            r = p - 1'b1;
        return r;
    endfunction

    function automatic slot_t cell_addr(pos_t row, pos_t col);
        return SLOT_W'(int'(row) * SIDE + int'(col));
    endfunction

endpackage

@@ src/pfd_in_if.sv @@
// Input channel: key loads and cipher digraphs.
interface pfd_in_if;
    logic                  valid;
    logic                  ready;
    logic                  cmd;
    pfd_pkg::slot_t        slot;
    pfd_pkg::byte_t        key_byte;
    pfd_pkg::byte_t        cipher_first;
    pfd_pkg::byte_t        cipher_second;

    modport source (output valid, cmd, slot, key_byte, cipher_first, cipher_second,
                    input ready);
    modport sink   (input valid, cmd, slot, key_byte, cipher_first, cipher_second,
                    output ready);
endinterface

@@ src/pfd_out_if.sv @@
// Output channel: decrypted digraphs.
interface pfd_out_if;
    logic           valid;
    logic           ready;
    pfd_pkg::byte_t plain_first;
    pfd_pkg::byte_t plain_second;
    logic           not_found;

    modport source (output valid, plain_first, plain_second, not_found, input ready);
    modport sink   (input valid, plain_first, plain_second, not_found, output ready);
endinterface

@@ src/pfd_lane.sv @@
// One key square cell compared against both cipher bytes.
module pfd_lane (
    input  pfd_pkg::byte_t    entry,
    input  pfd_pkg::byte_t    cipher_first,
    input  pfd_pkg::byte_t    cipher_second,
    output pfd_pkg::lane_hit_t hit
);

    assign hit.first  = (entry == cipher_first);
    assign hit.second = (entry == cipher_second);

endmodule

@@ src/pfd_merge.sv @@
// Merges lane hits into positions and applies the Playfair rules.
module pfd_merge (
    input  logic [pfd_pkg::CELLS-1:0] hit_first,
    input  logic [pfd_pkg::CELLS-1:0] hit_second,
    output pfd_pkg::target_t          tgt
);

    always_comb
    begin
        logic          found_a;
        logic          found_b;
        pfd_pkg::pos_t ra;
        pfd_pkg::pos_t ca;
        pfd_pkg::pos_t rb;
        pfd_pkg::pos_t cb;
        pfd_pkg::pos_t pa_r;
        pfd_pkg::pos_t pa_c;
        pfd_pkg::pos_t pb_r;
        pfd_pkg::pos_t pb_c;

        found_a = 1'b0;
        found_b = 1'b0;
        ra = '0;
        ca = '0;
        rb = '0;
        cb = '0;
        // later cells override earlier ones: last match in row-major order
        for (int r = 0; r < pfd_pkg::SIDE; r++)
        begin
            for (int c = 0; c < pfd_pkg::SIDE; c++)
            begin
                if (hit_first[r * pfd_pkg::SIDE + c])
                begin
                    found_a = 1'b1;
                    ra = pfd_pkg::POS_W'(r);
                    ca = pfd_pkg::POS_W'(c);
                end
                if (hit_second[r * pfd_pkg::SIDE + c])
                begin
                    found_b = 1'b1;
                    rb = pfd_pkg::POS_W'(r);
                    cb = pfd_pkg::POS_W'(c);
                end
            end
        end

        if (ra == rb)
        begin
            pa_r = ra;
            pa_c = pfd_pkg::step_back(ca);
            pb_r = rb;
            pb_c = pfd_pkg::step_back(cb);
        end
        else if (ca == cb)
        begin
            pa_r = pfd_pkg::step_back(ra);
            pa_c = ca;
            pb_r = pfd_pkg::step_back(rb);
            pb_c = cb;
        end
        else
        begin
            pa_r = ra;
            pa_c = cb;
            pb_r = rb;
            pb_c = ca;
        end

        tgt.addr_first  = pfd_pkg::cell_addr(pa_r, pa_c);
        tgt.addr_second = pfd_pkg::cell_addr(pb_r, pb_c);
        tgt.not_found   = !(found_a && found_b);
    end

endmodule

@@ src/pfd_readout.sv @@
// Two-read key square copy and the registered result word.
module pfd_readout (
    input  logic              clk,
    input  logic              wr_en,
    input  pfd_pkg::slot_t    wr_addr,
    input  pfd_pkg::byte_t    wr_data,
    input  logic              rd_en,
    input  pfd_pkg::target_t  tgt,
    output pfd_pkg::byte_t    plain_first,
    output pfd_pkg::byte_t    plain_second,
    output logic              not_found
);

    pfd_pkg::byte_t mem [pfd_pkg::CELLS];
    pfd_pkg::byte_t first_reg;
    pfd_pkg::byte_t second_reg;
    logic           nf_reg;

    // reads see the contents before a same-edge write
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
        begin
            first_reg  <= mem[tgt.addr_first];
            second_reg <= mem[tgt.addr_second];
            nf_reg     <= tgt.not_found;
        end
    end

    assign plain_first  = nf_reg ? '0 : first_reg;
    assign plain_second = nf_reg ? '0 : second_reg;
    assign not_found    = nf_reg;

endmodule

@@ src/playfair_digraph_decrypt_top.sv @@
// Top level of the Playfair digraph decrypter.
// Usage:
//   cipher (sink): one word per handshake. cmd = load writes key_byte into the
//     key square at slot (0..24, row-major; higher slots are ignored) and gives
//     no result. cmd = decrypt carries cipher_first/cipher_second and gives one
//     word on plain.
//   plain (source): plain_first, plain_second and not_found. not_found is set
//     when either cipher byte is absent from the square; both bytes are then 0.
//   Load all 25 cells before the first decrypt.
// Timing: an accepted decrypt is registered in stage one and moves to stage two
//   while plain is not held off, one word per cycle. Stage one holds 25 compare
//   lanes over the square registers plus the merge; stage two reads the two
//   result cells from a two-read copy of the square into the output register.
// Reset: clears the pipeline valid flags only; square contents stay undefined
//   until loaded.
// Stall: while plain is held off, stage one holds; cipher.ready drops only once
//   stage one is full, so one further word is still taken.
module playfair_digraph_decrypt_top (
    input  logic         clk,
    input  logic         rst_n,
    pfd_in_if.sink       cipher,
    pfd_out_if.source    plain
);

    pfd_pkg::byte_t     key_square_reg [pfd_pkg::CELLS];
    pfd_pkg::lane_hit_t lane_hit [pfd_pkg::CELLS];
    logic [pfd_pkg::CELLS-1:0] hit_first;
    logic [pfd_pkg::CELLS-1:0] hit_second;
    pfd_pkg::target_t   tgt;
    pfd_pkg::target_t   tgt_reg;

    logic s1_valid_reg;
    logic s1_valid_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic advance;
    logic accept;
    logic load_wr;
    logic is_decrypt;

    // handshake
    assign advance    = !out_valid_reg || plain.ready;
    assign cipher.ready = !s1_valid_reg || advance;
    assign accept     = cipher.valid && cipher.ready;
    assign is_decrypt = (cipher.cmd == pfd_pkg::CMD_DECRYPT);
    assign load_wr    = accept && !is_decrypt &&
                        (cipher.slot < pfd_pkg::SLOT_W'(pfd_pkg::CELLS));

    // square registers feeding the lanes
    always_ff @(posedge clk)
    begin
        if (load_wr)
            key_square_reg[cipher.slot] <= cipher.key_byte;
    end

    // compare lanes, one per cell
    for (genvar i = 0; i < pfd_pkg::CELLS; i++)
    begin : g_lane
        pfd_lane u_lane (
            .entry         (key_square_reg[i]),
            .cipher_first  (cipher.cipher_first),
            .cipher_second (cipher.cipher_second),
            .hit           (lane_hit[i])
        );
        assign hit_first[i]  = lane_hit[i].first;
        assign hit_second[i] = lane_hit[i].second;
    end

    pfd_merge u_merge (
        .hit_first  (hit_first),
        .hit_second (hit_second),
        .tgt        (tgt)
    );

    // stage one: cells to read
    always_ff @(posedge clk)
    begin
        if (accept && is_decrypt)
            tgt_reg <= tgt;
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (cipher.ready)
            s1_valid_next = accept && is_decrypt;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // stage two: read-out and result word
    pfd_readout u_readout (
        .clk          (clk),
        .wr_en        (load_wr),
        .wr_addr      (cipher.slot),
        .wr_data      (cipher.key_byte),
        .rd_en        (advance && s1_valid_reg),
        .tgt          (tgt_reg),
        .plain_first  (plain.plain_first),
        .plain_second (plain.plain_second),
        .not_found    (plain.not_found)
    );

    assign plain.valid = out_valid_reg;

    // back-pressure only when both stages are full and the output is held
    a_ready_low_only_when_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        !cipher.ready |-> (s1_valid_reg && out_valid_reg && !plain.ready))
        else $error("input stalled with room in the pipeline");

    // an accepted word fills stage one exactly when it is a decrypt
    a_stage_one_fill: assert property (
        @(posedge clk) disable iff (!rst_n)
        (cipher.valid && cipher.ready) |=>
            (s1_valid_reg == ($past(cipher.cmd) == pfd_pkg::CMD_DECRYPT)))
        else $error("stage one valid does not follow accepted command");

    // a pending digraph is never dropped while the output is stalled
    a_stage_one_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !plain.ready) |=>
            (s1_valid_reg && out_valid_reg))
        else $error("pending digraph lost during stall");

endmodule
